/* rtl/wcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted category sampler package
// Sequencer states, status codes, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package wcs_pkg;

   localparam int FRAC_BITS  = 24;
   localparam int FRAC_CNT_W = $clog2(FRAC_BITS);

   localparam int CATEGORY_W = 6;
   localparam int WEIGHT_W   = 32;
   localparam int INDEX_W    = 6;
   localparam int STATUS_W   = 2;
   localparam int NUMCAT_W   = 7;
   localparam int COUNT_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic ACTION_LOAD   = 1'b0;
   localparam logic ACTION_SAMPLE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERDRAWN = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CATEGORIES   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES_PER_ROW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WITH_REPLACEMENT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MUL,
      ST_SEARCH,
      ST_CLEAR,
      ST_DONE
   } state_type;

endpackage

/* rtl/wcs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wcs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/weighted_category_sampler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted category sampler
// Inverse-CDF sampling over a row of unnormalized integer weights.
// ----------------------------------------------------------------------------
// A load transfer (tuser = 0) writes one weight at the edge where it is accepted
// and leaves the block ready in the next cycle. A sample transfer (tuser = 1)
// holds the input off from its acceptance until its result is handed to the
// output register. It makes one pass over the weight RAM to form the total (the
// last step of which decides between an empty row and the multiply), a 24-step
// shift-and-add multiply of u by the total, a second RAM pass that stops at the
// first running sum reaching the scaled threshold or else at the last category
// in use, a clear step to zero the chosen weight when drawing without
// replacement, and the hand-off of the result to the output register. An empty
// row skips the multiply and the search, and a draw refused for asking too many
// samples skips both passes. The hand-off waits as long as the output register
// still holds a result the receiver has not taken. The running sums and the
// multiply steps go through one shared adder, and the single RAM read port sets
// the pace of both passes. The result register lets the next transfer be
// accepted while the previous result is still waiting.
// ----------------------------------------------------------------------------
module weighted_category_sampler #(
   parameter int MAX_CATEGORIES = 64,
   parameter int WEIGHT_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: category [5:0], weight [37:6], uniform_fraction [61:38]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   // req_tuser: action [0]
   input  logic        req_tuser,
   // rsp_tdata: chosen_index [5:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   // rsp_tuser: status [1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data
);

   localparam int AW     = $clog2(MAX_CATEGORIES);
   localparam int CW     = $clog2(MAX_CATEGORIES + 1);
   localparam int SUM_W  = WEIGHT_BITS + AW;
   localparam int PROD_W = SUM_W + wcs_pkg::FRAC_BITS;
   localparam logic [31:0] MAX_CAT_WORD = 32'(MAX_CATEGORIES);

   // Input fields.
   logic                                 in_action;
   logic [wcs_pkg::CATEGORY_W-1:0]       in_category;
   logic [wcs_pkg::WEIGHT_W-1:0]         in_weight;
   logic [wcs_pkg::FRAC_BITS-1:0]        in_fraction;

   assign in_category = req_tdata[5:0];
   assign in_weight   = req_tdata[37:6];
   assign in_fraction = req_tdata[61:38];
   assign in_action   = req_tuser;

   // Control registers.
   wcs_pkg::state_type               state_ff, state_in;
   logic [wcs_pkg::NUMCAT_W-1:0]     num_cat_ff, num_cat_in;
   logic [wcs_pkg::COUNT_W-1:0]      spr_ff, spr_in;
   logic                             with_repl_ff, with_repl_in;
   logic [wcs_pkg::COUNT_W-1:0]      taken_ff, taken_in;
   logic [CW-1:0]                    cnt_ff, cnt_in;
   logic                             rd_valid_ff, rd_valid_in;
   logic [wcs_pkg::FRAC_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [CW-1:0]                    n_ff, n_in;
   logic [wcs_pkg::FRAC_BITS-1:0]    u_ff, u_in;
   logic [AW-1:0]                    rd_idx_ff, rd_idx_in;
   logic [SUM_W-1:0]                 acc_ff, acc_in;
   logic [PROD_W-1:0]                prod_ff, prod_in;
   logic [AW-1:0]                    idx_ff, idx_in;
   logic [wcs_pkg::STATUS_W-1:0]     status_ff, status_in;
   logic [wcs_pkg::INDEX_W-1:0]      rsp_idx_ff, rsp_idx_in;
   logic [wcs_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic                             rsp_last_ff, rsp_last_in;

   // RAM port signals.
   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [WEIGHT_BITS-1:0] ram_wr_data;
   logic [WEIGHT_BITS-1:0] ram_rd_data;

   // Shared adder and helpers.
   logic [PROD_W-1:0]            add_a;
   logic [PROD_W-1:0]            add_b;
   logic [PROD_W-1:0]            add_sum;
   logic [SUM_W-1:0]             run_new;
   logic                         hit;
   logic                         rd_issue;
   logic                         in_xfer;
   logic [CW-1:0]                n_clamped;
   logic [wcs_pkg::COUNT_W-1:0]  taken_next;

   wcs_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (MAX_CATEGORIES)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == wcs_pkg::ST_IDLE);
   assign in_xfer    = req_tvalid && req_tready;
   assign rd_issue   = ((state_ff == wcs_pkg::ST_SUM) || (state_ff == wcs_pkg::ST_SEARCH))
                       && (cnt_ff < n_ff);

   always_comb begin
      if (num_cat_ff == '0) begin
         n_clamped = CW'(1);
      end else if (32'(num_cat_ff) > MAX_CAT_WORD) begin
         n_clamped = CW'(MAX_CATEGORIES);
      end else begin
         n_clamped = CW'(num_cat_ff);
      end
   end

   // The multiply step doubles the partial product and adds the total when
   // the current fraction bit is set; the walks add the RAM word to the sum.
   always_comb begin
      if (state_ff == wcs_pkg::ST_MUL) begin
         add_a = prod_ff << 1;
         add_b = u_ff[wcs_pkg::FRAC_BITS-1] ? PROD_W'(acc_ff) : '0;
      end else begin
         add_a = PROD_W'(acc_ff);
         add_b = PROD_W'(ram_rd_data);
      end
      add_sum = add_a + add_b;
      run_new = add_sum[SUM_W-1:0];
      hit     = {run_new, {wcs_pkg::FRAC_BITS{1'b0}}} >= prod_ff;
   end

   assign taken_next = (taken_ff != {wcs_pkg::COUNT_W{1'b1}}) ?
                       taken_ff + wcs_pkg::COUNT_W'(1) : taken_ff;

   always_comb begin
      state_in      = state_ff;
      num_cat_in    = num_cat_ff;
      spr_in        = spr_ff;
      with_repl_in  = with_repl_ff;
      taken_in      = taken_ff;
      cnt_in        = cnt_ff;
      rd_valid_in   = rd_valid_ff;
      bit_cnt_in    = bit_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      n_in          = n_ff;
      u_in          = u_ff;
      rd_idx_in     = rd_idx_ff;
      acc_in        = acc_ff;
      prod_in       = prod_ff;
      idx_in        = idx_ff;
      status_in     = status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = AW'(in_category);
      ram_wr_data   = in_weight[WEIGHT_BITS-1:0];

      if (csr_wr_en) begin
         case (csr_index)
            wcs_pkg::CSR_NUM_CATEGORIES:   num_cat_in   = csr_wr_data[wcs_pkg::NUMCAT_W-1:0];
            wcs_pkg::CSR_SAMPLES_PER_ROW:  spr_in       = csr_wr_data;
            wcs_pkg::CSR_WITH_REPLACEMENT: with_repl_in = csr_wr_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         wcs_pkg::ST_IDLE: begin
            if (in_xfer) begin
               if (in_action == wcs_pkg::ACTION_LOAD) begin
                  ram_wr_en = (32'(in_category) < MAX_CAT_WORD);
                  taken_in  = '0;
               end else begin
                  n_in        = n_clamped;
                  u_in        = in_fraction;
                  cnt_in      = '0;
                  rd_valid_in = 1'b0;
                  acc_in      = '0;
                  idx_in      = '0;
                  if (!with_repl_ff && (32'(spr_ff) > 32'(n_clamped))) begin
                     status_in = wcs_pkg::STATUS_OVERDRAWN;
                     state_in  = wcs_pkg::ST_DONE;
                  end else begin
                     state_in  = wcs_pkg::ST_SUM;
                  end
               end
            end
         end

         wcs_pkg::ST_SUM: begin
            if (rd_issue) begin
               cnt_in = cnt_ff + CW'(1);
            end
            rd_valid_in = rd_issue;
            rd_idx_in   = cnt_ff[AW-1:0];
            if (rd_valid_ff) begin
               acc_in = run_new;
            end
            if (!rd_issue && !rd_valid_ff) begin
               if (acc_ff == '0) begin
                  status_in = wcs_pkg::STATUS_EMPTY;
                  state_in  = wcs_pkg::ST_DONE;
               end else begin
                  prod_in    = '0;
                  bit_cnt_in = '0;
                  state_in   = wcs_pkg::ST_MUL;
               end
            end
         end

         wcs_pkg::ST_MUL: begin
            prod_in    = add_sum;
            u_in       = u_ff << 1;
            bit_cnt_in = bit_cnt_ff + wcs_pkg::FRAC_CNT_W'(1);
            if (bit_cnt_ff == wcs_pkg::FRAC_CNT_W'(wcs_pkg::FRAC_BITS - 1)) begin
               cnt_in      = '0;
               rd_valid_in = 1'b0;
               acc_in      = '0;
               state_in    = wcs_pkg::ST_SEARCH;
            end
         end

         wcs_pkg::ST_SEARCH: begin
            if (rd_issue) begin
               cnt_in = cnt_ff + CW'(1);
            end
            rd_valid_in = rd_issue;
            rd_idx_in   = cnt_ff[AW-1:0];
            if (rd_valid_ff) begin
               acc_in = run_new;
               // The last category in use is taken when no earlier one reaches it.
               if (hit || (CW'(rd_idx_ff) == n_ff - CW'(1))) begin
                  idx_in    = rd_idx_ff;
                  status_in = wcs_pkg::STATUS_OK;
                  state_in  = with_repl_ff ? wcs_pkg::ST_DONE : wcs_pkg::ST_CLEAR;
               end
            end
         end

         wcs_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = '0;
            state_in    = wcs_pkg::ST_DONE;
         end

         wcs_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_idx_in    = wcs_pkg::INDEX_W'(idx_ff);
               rsp_status_in = status_ff;
               rsp_last_in   = (spr_ff != '0) && (taken_next == spr_ff);
               taken_in      = taken_next;
               state_in      = wcs_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = wcs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wcs_pkg::ST_IDLE;
         num_cat_ff   <= wcs_pkg::NUMCAT_W'(64);
         spr_ff       <= wcs_pkg::COUNT_W'(1);
         with_repl_ff <= 1'b1;
         taken_ff     <= '0;
         cnt_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         num_cat_ff   <= num_cat_in;
         spr_ff       <= spr_in;
         with_repl_ff <= with_repl_in;
         taken_ff     <= taken_in;
         cnt_ff       <= cnt_in;
         rd_valid_ff  <= rd_valid_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      u_ff          <= u_in;
      rd_idx_ff     <= rd_idx_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_idx_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* test/weighted_category_sampler_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted category sampler testbench
// Loads rows of weights and draws samples through the request stream. Each
// sample result is checked against a cycle-free inverse-CDF predictor kept in
// step with every accepted transfer. Directed cases cover fraction extremes,
// exact threshold ties, empty rows, drawing without replacement and one long
// receiver hold-off. Random rows follow under changing register settings,
// random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module weighted_category_sampler_test;

   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int ITEM_TARGET  = 1400;
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_CYCLES  = 2000;
   localparam int REPORT_LIMIT = 10;
   localparam int ROW_DEPTH    = 64;

   typedef struct packed {
      bit [wcs_pkg::INDEX_W-1:0]  index;
      bit [wcs_pkg::STATUS_W-1:0] status;
      bit                         last;
   } draw_type;

   typedef enum {RX_ALWAYS, RX_COIN, RX_CADENCE, RX_SPARSE} rx_pattern_type;
   typedef enum {ROW_RANDOM, ROW_TINY, ROW_SPIKE, ROW_FULL, ROW_SPARSE} row_shape_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = wcs_pkg::ACTION_LOAD;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = wcs_pkg::CSR_NUM_CATEGORIES;
   logic [15:0] csr_wr_data = '0;

   weighted_category_sampler dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: the weight row, the draw count and the registers.
   bit [wcs_pkg::WEIGHT_W-1:0] weight_row [ROW_DEPTH];
   bit [wcs_pkg::COUNT_W-1:0]  draws_taken = '0;
   bit [wcs_pkg::NUMCAT_W-1:0] cfg_num_categories = 7'd64;
   bit [wcs_pkg::COUNT_W-1:0]  cfg_samples_per_row = 16'd1;
   bit                         cfg_with_replacement = 1'b1;

   draw_type pending_draws [$];
   draw_type head_draw;

   int mismatch_count = 0;
   int items_sent = 0;
   int load_count = 0;
   int draw_count = 0;
   int checked_count = 0;
   int last_tally = 0;
   int status_tally [3] = '{0, 0, 0};
   int cycle_count = 0;
   int burst_left = 0;
   bit steady_sender = 1'b0;
   int hold_left = 0;
   int stall_phase = 0;
   rx_pattern_type stall_mode = RX_ALWAYS;

   function automatic int effective_categories();
      if (cfg_num_categories == 0) return 1;
      if (int'(cfg_num_categories) > ROW_DEPTH) return ROW_DEPTH;
      return int'(cfg_num_categories);
   endfunction

   // Advances the predictor by one accepted transfer and queues the result
   // a draw produces.
   function automatic void predict_outcome(bit action,
                                           bit [wcs_pkg::CATEGORY_W-1:0] category,
                                           bit [wcs_pkg::WEIGHT_W-1:0] weight,
                                           bit [wcs_pkg::FRAC_BITS-1:0] u);
      draw_type   d;
      int         n;
      int         i;
      bit [37:0]  total;
      bit [37:0]  running;
      bit [63:0]  wide_u;
      bit [63:0]  threshold;
      if (action == wcs_pkg::ACTION_LOAD) begin
         weight_row[category] = weight;
         draws_taken = '0;
         load_count++;
         return;
      end
      draw_count++;
      n = effective_categories();
      d.index = '0;
      d.status = wcs_pkg::STATUS_OK;
      if (!cfg_with_replacement && int'(cfg_samples_per_row) > n) begin
         d.status = wcs_pkg::STATUS_OVERDRAWN;
      end else begin
         total = '0;
         for (i = 0; i < n; i++) total += 38'(weight_row[i]);
         if (total == 0) begin
            d.status = wcs_pkg::STATUS_EMPTY;
         end else begin
            // Exact compare of running_sum * 2^24 against u * total.
            wide_u = 64'(u);
            threshold = wide_u * 64'(total);
            running = '0;
            d.index = wcs_pkg::INDEX_W'(n - 1);
            for (i = 0; i < n; i++) begin
               running += 38'(weight_row[i]);
               if (64'({running, {wcs_pkg::FRAC_BITS{1'b0}}}) >= threshold) begin
                  d.index = wcs_pkg::INDEX_W'(i);
                  break;
               end
            end
            if (!cfg_with_replacement) weight_row[d.index] = '0;
         end
      end
      if (draws_taken != 16'hFFFF) draws_taken++;
      d.last = (cfg_samples_per_row != 0) && (draws_taken == cfg_samples_per_row);
      pending_draws = {pending_draws, d};
   endfunction

   // Sender with random bursts and gaps; the item counts once it is accepted.
   task automatic send_transfer(input bit action,
                                input bit [wcs_pkg::CATEGORY_W-1:0] category,
                                input bit [wcs_pkg::WEIGHT_W-1:0] weight,
                                input bit [wcs_pkg::FRAC_BITS-1:0] u);
      int gap;
      if (burst_left == 0) begin
         burst_left = int'($urandom_range(1, 12));
         if (steady_sender) gap = 0;
         else if ($urandom_range(0, 9) == 0) gap = int'($urandom_range(20, 150));
         else gap = int'($urandom_range(0, 8));
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser = action;
      req_tdata = {2'b00, u, weight, category};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_outcome(action, category, weight, u);
      items_sent++;
   endtask

   task automatic send_load(input int category, input bit [wcs_pkg::WEIGHT_W-1:0] weight);
      send_transfer(wcs_pkg::ACTION_LOAD, wcs_pkg::CATEGORY_W'(category), weight,
                    wcs_pkg::FRAC_BITS'($urandom));
   endtask

   task automatic send_draw(input bit [wcs_pkg::FRAC_BITS-1:0] u);
      send_transfer(wcs_pkg::ACTION_SAMPLE, wcs_pkg::CATEGORY_W'($urandom), $urandom, u);
   endtask

   // Lets every expected result arrive, then gives the block time to finish
   // any work that produces no result.
   task automatic drain_block();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (pending_draws.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [wcs_pkg::CSR_IDX_W-1:0] idx, input bit [15:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wr_data = data;
      case (idx)
         wcs_pkg::CSR_NUM_CATEGORIES:   cfg_num_categories = data[wcs_pkg::NUMCAT_W-1:0];
         wcs_pkg::CSR_SAMPLES_PER_ROW:  cfg_samples_per_row = data;
         wcs_pkg::CSR_WITH_REPLACEMENT: cfg_with_replacement = data[0];
         default: ;
      endcase
   endtask

   task automatic write_config(input bit [wcs_pkg::NUMCAT_W-1:0] n, input bit [15:0] per_row,
                               input bit keep);
      write_reg(wcs_pkg::CSR_NUM_CATEGORIES, 16'(n));
      write_reg(wcs_pkg::CSR_SAMPLES_PER_ROW, per_row);
      write_reg(wcs_pkg::CSR_WITH_REPLACEMENT, 16'(keep));
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic bit [wcs_pkg::WEIGHT_W-1:0] row_weight(row_shape_type shape, int i,
                                                             int spike);
      case (shape)
         ROW_TINY:   return $urandom_range(0, 3);
         ROW_SPIKE:  return (i == spike) ? $urandom : 32'd0;
         ROW_FULL:   return 32'hFFFF_FFFF;
         ROW_SPARSE: return ($urandom_range(0, 1) != 0) ? $urandom : 32'd0;
         default:    return $urandom;
      endcase
   endfunction

   task automatic load_row(input int count, input row_shape_type shape);
      int spike;
      int i;
      spike = int'($urandom_range(0, count - 1));
      for (i = 0; i < count; i++) send_load(i, row_weight(shape, i, spike));
   endtask

   function automatic bit [wcs_pkg::FRAC_BITS-1:0] pick_fraction();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 24'hFF_FFFF;
         2:       return wcs_pkg::FRAC_BITS'($urandom_range(0, 15));
         default: return wcs_pkg::FRAC_BITS'($urandom);
      endcase
   endfunction

   // A zero-weight first category is still chosen by a zero fraction; the
   // largest fraction lands on the category holding the full-scale weight.
   task automatic test_fraction_extremes();
      drain_block();
      write_config(7'd4, 16'd3, 1'b1);
      send_load(63, 32'hFFFF_FFFF);
      send_load(0, 32'd0);
      send_load(1, 32'd1);
      send_load(2, 32'hFFFF_FFFF);
      send_load(3, 32'd0);
      send_draw(24'd0);
      send_draw(24'hFF_FFFF);
      send_draw(24'd1);
   endtask

   // Equal weights make u * total hit a running sum exactly; a tie must pick
   // the lower category.
   task automatic test_exact_boundary();
      int i;
      for (i = 0; i < 4; i++) send_load(i, 32'd1);
      send_draw(24'h40_0000);
      send_draw(24'h40_0001);
      send_draw(24'hC0_0000);
      send_draw(24'hC0_0001);
   endtask

   task automatic test_empty_row();
      load_row(4, ROW_SPIKE);
      send_load(0, 32'd0);
      send_load(1, 32'd0);
      send_load(2, 32'd0);
      send_load(3, 32'd0);
      send_draw(pick_fraction());
   endtask

   // Asking for more draws than categories is refused outright; otherwise
   // each draw removes its category until the row runs dry.
   task automatic test_without_replacement();
      drain_block();
      write_config(7'd2, 16'd3, 1'b0);
      send_load(0, 32'd5);
      send_load(1, 32'd7);
      send_draw(24'h80_0000);
      drain_block();
      write_config(7'd2, 16'd2, 1'b0);
      send_load(0, 32'd5);
      send_load(1, 32'd7);
      send_draw(24'hFF_FFFF);
      send_draw(24'hFF_FFFF);
      send_draw(24'hFF_FFFF);
   endtask

   // Keeps the receiver stalled while the sender pushes draws back to back.
   task automatic test_backpressure();
      int i;
      drain_block();
      write_config(7'd8, 16'd200, 1'b1);
      load_row(8, ROW_RANDOM);
      steady_sender = 1'b1;
      hold_left = HOLD_CYCLES;
      for (i = 0; i < 30; i++) send_draw(pick_fraction());
      steady_sender = 1'b0;
   endtask

   task automatic test_random_rows();
      int phase;
      int n_eff;
      int draws;
      int k;
      bit [wcs_pkg::NUMCAT_W-1:0] n;
      bit [15:0] per_row;
      bit keep;
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         drain_block();
         // The first phases pin the register extremes.
         case (phase)
            0: begin n = 7'd1;   per_row = 16'd1;     keep = 1'b1; end
            1: begin n = 7'd64;  per_row = 16'd64;    keep = 1'b0; end
            2: begin n = 7'd0;   per_row = 16'd2;     keep = 1'b1; end
            3: begin n = 7'd100; per_row = 16'd0;     keep = 1'b1; end
            4: begin n = 7'd127; per_row = 16'hFFFF;  keep = 1'b0; end
            5: begin n = 7'd64;  per_row = 16'hFFFF;  keep = 1'b1; end
            default: begin
               case ($urandom_range(0, 9))
                  0:       n = 7'd64;
                  1:       n = wcs_pkg::NUMCAT_W'($urandom_range(65, 127));
                  2:       n = 7'd0;
                  default: n = wcs_pkg::NUMCAT_W'($urandom_range(1, 16));
               endcase
               n_eff = (n == 0) ? 1 : ((int'(n) > ROW_DEPTH) ? ROW_DEPTH : int'(n));
               case ($urandom_range(0, 5))
                  0:       per_row = 16'd0;
                  1:       per_row = 16'd1;
                  2:       per_row = 16'(n_eff);
                  3:       per_row = 16'(n_eff + 1);
                  4:       per_row = 16'($urandom_range(1, 65535));
                  default: per_row = 16'($urandom_range(1, n_eff));
               endcase
               keep = 1'($urandom_range(0, 1));
            end
         endcase
         phase++;
         write_config(n, per_row, keep);
         n_eff = effective_categories();
         steady_sender = ($urandom_range(0, 3) == 0);
         load_row(n_eff, row_shape_type'($urandom_range(0, 4)));
         if (!keep && int'(per_row) <= n_eff) draws = int'(per_row) + int'($urandom_range(0, 2));
         else draws = int'($urandom_range(6, 40));
         for (k = 0; k < draws; k++) begin
            if ($urandom_range(0, 11) == 0) send_load(int'($urandom_range(0, 63)), $urandom);
            send_draw(pick_fraction());
         end
      end
      steady_sender = 1'b0;
   endtask

   // Receiver: a forced hold-off wins, otherwise the current stall pattern,
   // which is itself picked anew at random, decides.
   always @(negedge clock) begin
      stall_phase++;
      if (stall_phase % 400 == 0) stall_mode = rx_pattern_type'($urandom_range(0, 3));
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else begin
         case (stall_mode)
            RX_COIN:    rsp_tready = 1'($urandom_range(0, 1));
            RX_CADENCE: rsp_tready = (stall_phase % 4 == 0);
            RX_SPARSE:  rsp_tready = ($urandom_range(0, 7) == 0);
            default:    rsp_tready = 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_draws.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("Unexpected result at cycle %0d: index %0d status %0d last %0d",
                        cycle_count, rsp_tdata[wcs_pkg::INDEX_W-1:0], rsp_tuser, rsp_tlast);
         end else begin
            head_draw = pending_draws.pop_front();
            checked_count++;
            if (head_draw.status < 3) status_tally[head_draw.status]++;
            if (head_draw.last) last_tally++;
            if (rsp_tdata[wcs_pkg::INDEX_W-1:0] != head_draw.index ||
                rsp_tuser != head_draw.status || rsp_tlast != head_draw.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"Mismatch on draw %0d at cycle %0d: expected index %0d ",
                            "status %0d last %0d, got index %0d status %0d last %0d"},
                           checked_count, cycle_count, head_draw.index, head_draw.status,
                           head_draw.last, rsp_tdata[wcs_pkg::INDEX_W-1:0], rsp_tuser,
                           rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d draws pending",
                  cycle_count, pending_draws.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_fraction_extremes();
      test_exact_boundary();
      test_empty_row();
      test_without_replacement();
      test_backpressure();
      test_random_rows();
      drain_block();
      $display("Sent %0d transfers (%0d loads, %0d draws) over %0d cycles.",
               items_sent, load_count, draw_count, cycle_count);
      $display("Checked %0d draws: %0d ok, %0d empty row, %0d overdrawn, %0d row ends.",
               checked_count, status_tally[0], status_tally[1], status_tally[2], last_tally);
      if (mismatch_count == 0 && pending_draws.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d draws never returned",
                  mismatch_count, pending_draws.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
